@@ sv/ivt_pkg.sv @@
// Shared constants, status codes and control structs for the interval value table.
package ivt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 8;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 3);

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;    // command transfer accepted
		logic eval;    // evaluate the entry in the read register
		logic commit;  // finish: update table and latch result
	} ivt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty_in;  // incoming assign has an empty range
		logic adv;       // move on to the next entry
		logic fin;       // scan complete
	} ivt_stat_t;

endpackage

@@ sv/ivt_ctrl.sv @@
// Controller state machine: sequences the entry scan of one command.
module ivt_ctrl import ivt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ivt_stat_t stat,
	output ivt_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EV   = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = stat.empty_in ? S_FIN : S_RD;
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				if (stat.fin)      state_d = S_FIN;
				else if (stat.adv) state_d = S_RD;
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.eval   = (state_q == S_EV);
	assign cmd.commit = (state_q == S_FIN);

endmodule

@@ sv/ivt_dp.sv @@
// Datapath: two table banks, scan pointers, merge logic and result registers.
module ivt_dp import ivt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ivt_cmd_t                cmd,
	output ivt_stat_t               stat,
	input  logic                    default_value_we,
	input  logic [VAL_W-1:0]        default_value,
	input  logic                    command,
	input  logic signed [KEY_W-1:0] range_begin,
	input  logic signed [KEY_W-1:0] range_end,
	input  logic [VAL_W-1:0]        new_value,
	input  logic signed [KEY_W-1:0] lookup_key,
	output logic [VAL_W-1:0]        read_value,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        count
);

	// banks hold {key, value}; one is read, the other rebuilt
	logic [KEY_W+VAL_W-1:0] bank0 [MAX_ENTRIES];
	logic [KEY_W+VAL_W-1:0] bank1 [MAX_ENTRIES];
	logic [KEY_W+VAL_W-1:0] rd0_q, rd1_q;

	logic                    sel_q;
	logic [CNT_W-1:0]        cnt_q, rd_q, wr_q;
	logic [1:0]              ph_q;
	logic [VAL_W-1:0]        dflt_q, cur_q, val_q, rv_q;
	logic [1:0]              st_q;
	logic                    op_q, empty_q;
	logic signed [KEY_W-1:0] b_q, e_q, lk_q;

	logic                    at_end;
	logic signed [KEY_W-1:0] k;
	logic [VAL_W-1:0]        v;
	logic                    wen, adv, fin, cur_ld;
	logic [1:0]              ph_d;
	logic [KEY_W+VAL_W-1:0]  wdata;

	assign at_end = (rd_q == cnt_q);
	assign k      = sel_q ? rd1_q[KEY_W+VAL_W-1:VAL_W] : rd0_q[KEY_W+VAL_W-1:VAL_W];
	assign v      = sel_q ? rd1_q[VAL_W-1:0] : rd0_q[VAL_W-1:0];

	// merge decision for the current entry
	always_comb begin
		wen    = 1'b0;
		adv    = 1'b0;
		fin    = 1'b0;
		cur_ld = 1'b0;
		ph_d   = ph_q;
		wdata  = {k, v};
		if (op_q == CMD_LOOKUP) begin
			if (at_end || k > lk_q) fin = 1'b1;
			else begin
				cur_ld = 1'b1;
				adv    = 1'b1;
			end
		end else begin
			case (ph_q)
				2'd0: begin
					if (at_end || k >= b_q) begin
						wen   = (cur_q != val_q);
						wdata = {b_q, val_q};
						ph_d  = 2'd1;
					end else begin
						wen    = 1'b1;
						cur_ld = 1'b1;
						adv    = 1'b1;
					end
				end
				2'd1: begin
					if (at_end || k > e_q) begin
						wen   = (cur_q != val_q);
						wdata = {e_q, cur_q};
						ph_d  = 2'd2;
					end else begin
						cur_ld = 1'b1;
						adv    = 1'b1;
					end
				end
				default: begin
					if (at_end) fin = 1'b1;
					else begin
						wen = 1'b1;
						adv = 1'b1;
					end
				end
			endcase
		end
	end

	assign stat.empty_in = (command == CMD_ASSIGN) && !(range_begin < range_end);
	assign stat.adv      = adv;
	assign stat.fin      = fin;

	// bank access
	always_ff @(posedge clk) begin
		rd0_q <= bank0[rd_q[IDX_W-1:0]];
		rd1_q <= bank1[rd_q[IDX_W-1:0]];
		if (cmd.eval && wen && wr_q < CNT_W'(MAX_ENTRIES)) begin
			if (sel_q) bank0[wr_q[IDX_W-1:0]] <= wdata;
			else       bank1[wr_q[IDX_W-1:0]] <= wdata;
		end
	end

	// command operands and scan state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= command;
			b_q     <= range_begin;
			e_q     <= range_end;
			lk_q    <= lookup_key;
			val_q   <= new_value;
			empty_q <= stat.empty_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= 1'b0;
			cnt_q  <= '0;
			rd_q   <= '0;
			wr_q   <= '0;
			ph_q   <= 2'd0;
			dflt_q <= '0;
			cur_q  <= '0;
			rv_q   <= '0;
			st_q   <= ST_DONE;
		end else begin
			if (default_value_we) dflt_q <= default_value;
			if (cmd.load) begin
				rd_q  <= '0;
				wr_q  <= '0;
				ph_q  <= 2'd0;
				cur_q <= dflt_q;
			end
			if (cmd.eval) begin
				ph_q <= ph_d;
				if (cur_ld) cur_q <= v;
				if (adv)    rd_q  <= rd_q + 1'b1;
				if (wen)    wr_q  <= wr_q + 1'b1;
			end
			// commit result and swap banks on a successful assign
			if (cmd.commit) begin
				rv_q <= (op_q == CMD_LOOKUP) ? cur_q : '0;
				if (op_q == CMD_LOOKUP) begin
					st_q <= ST_DONE;
				end else if (empty_q) begin
					st_q <= ST_EMPTY;
				end else if (wr_q > CNT_W'(MAX_ENTRIES)) begin
					st_q <= ST_FULL;
				end else begin
					st_q  <= ST_DONE;
					sel_q <= ~sel_q;
					cnt_q <= wr_q;
				end
			end
		end
	end

	assign read_value = rv_q;
	assign status     = st_q;
	assign count      = cnt_q;

endmodule

@@ sv/interval_value_table.sv @@
// Interval value table: one command at a time; start transfers only while busy is low.
// An assign reads and evaluates each entry, reads and evaluates once more at the table
// end, evaluates the two boundary inserts and commits. A lookup reads and evaluates
// entries up to a key above lookup_key or the table end, then commits; an empty range
// goes straight to the commit. done shows the result in the cycle after the commit and
// cannot be stalled; the next start may transfer then. Reset empties the table, default 0.
module interval_value_table import ivt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	output logic                    done,
	input  logic                    default_value_we,
	input  logic [VAL_W-1:0]        default_value,
	input  logic                    command,
	input  logic signed [KEY_W-1:0] range_begin,
	input  logic signed [KEY_W-1:0] range_end,
	input  logic [VAL_W-1:0]        new_value,
	input  logic signed [KEY_W-1:0] lookup_key,
	output logic [VAL_W-1:0]        read_value,
	output logic [1:0]              status
);

	ivt_cmd_t         cmd;
	ivt_stat_t        stat;
	logic [CNT_W-1:0] count;

	ivt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ivt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.default_value_we (default_value_we),
		.default_value    (default_value),
		.command          (command),
		.range_begin      (range_begin),
		.range_end        (range_end),
		.new_value        (new_value),
		.lookup_key       (lookup_key),
		.read_value       (read_value),
		.status           (status),
		.count            (count)
	);

	// a transfer in makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");

	// a result follows a commit cycle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.commit)) else $error("stray result");

	// the table never outgrows its storage
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");

	// empty and refused assigns leave the count alone
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> $stable(count)) else $error("count changed");

endmodule

@@ bench/interval_value_table_check.sv @@
// Checker for the interval value table: watches transfers, predicts results, compares.
module interval_value_table_check import ivt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic                    done,
	input  logic                    default_value_we,
	input  logic [VAL_W-1:0]        default_value,
	input  logic                    command,
	input  logic signed [KEY_W-1:0] range_begin,
	input  logic signed [KEY_W-1:0] range_end,
	input  logic [VAL_W-1:0]        new_value,
	input  logic signed [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0]        read_value,
	input  logic [1:0]              status,
	output int                      mismatches,
	output int                      pending,
	output int                      n_lookups,
	output int                      n_empty,
	output int                      n_full
);

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [1:0]       st;
	} table_result_t;

	// mirror of the table contents
	logic signed [KEY_W-1:0] map_key [MAX_ENTRIES];
	logic [VAL_W-1:0]        map_val [MAX_ENTRIES];
	int                      map_count;
	logic [VAL_W-1:0]        map_default;
	table_result_t           expected_results[$];

	// value in force at key k (or just below k when strict)
	function automatic logic [VAL_W-1:0] value_in_force(logic signed [KEY_W-1:0] k, bit strict);
		logic [VAL_W-1:0] v;
		v = map_default;
		for (int i = 0; i < map_count; i++) begin
			if (strict ? (map_key[i] >= k) : (map_key[i] > k))
				break;
			v = map_val[i];
		end
		return v;
	endfunction

	// write v over [b, e), keeping the table canonical
	function automatic logic [1:0] paint_range(logic signed [KEY_W-1:0] b,
			logic signed [KEY_W-1:0] e, logic [VAL_W-1:0] v);
		logic signed [KEY_W-1:0] nk [MAX_ENTRIES + 2];
		logic [VAL_W-1:0]        nv [MAX_ENTRIES + 2];
		logic [VAL_W-1:0]        below, after;
		int                      n;
		n = 0;
		if (!(b < e))
			return ST_EMPTY;
		below = value_in_force(b, 1'b1);
		after = value_in_force(e, 1'b0);
		for (int i = 0; i < map_count; i++)
			if (map_key[i] < b) begin
				nk[n] = map_key[i];
				nv[n] = map_val[i];
				n++;
			end
		if (below != v) begin
			nk[n] = b;
			nv[n] = v;
			n++;
		end
		if (after != v) begin
			nk[n] = e;
			nv[n] = after;
			n++;
		end
		for (int i = 0; i < map_count; i++)
			if (map_key[i] > e) begin
				if (n >= MAX_ENTRIES + 2)
					return ST_FULL;
				nk[n] = map_key[i];
				nv[n] = map_val[i];
				n++;
			end
		if (n > MAX_ENTRIES)
			return ST_FULL;
		for (int i = 0; i < n; i++) begin
			map_key[i] = nk[i];
			map_val[i] = nv[i];
		end
		map_count = n;
		return ST_DONE;
	endfunction

	assign pending = expected_results.size();

	// predict on each command transfer, compare on each done strobe
	always @(posedge clk or negedge arst_n) begin
		table_result_t r, want;
		if (!arst_n) begin
			map_count   = 0;
			map_default = '0;
			expected_results.delete();
			mismatches  = 0;
			n_lookups   = 0;
			n_empty     = 0;
			n_full      = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: read_value %0d status %0d", read_value, status);
				end else begin
					want = expected_results.pop_front();
					if (want.value !== read_value || want.st !== status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: read_value exp %0d got %0d, status exp %0d got %0d",
								want.value, read_value, want.st, status);
					end
				end
			end
			if (start && !busy) begin
				r = '0;
				if (command == CMD_LOOKUP) begin
					r.value = value_in_force(lookup_key, 1'b0);
					n_lookups++;
				end else begin
					r.st = paint_range(range_begin, range_end, new_value);
					if (r.st == ST_EMPTY) n_empty++;
					if (r.st == ST_FULL) n_full++;
				end
				expected_results.push_back(r);
			end
			if (default_value_we)
				map_default = default_value;
		end
	end

endmodule

@@ bench/interval_value_table_test.sv @@
// Top of the interval value table testbench: clock, reset, stimulus and verdict.
module interval_value_table_test import ivt_pkg::*;;

	localparam int CYCLE_LIMIT = 2000000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    done;
	logic                    default_value_we;
	logic [VAL_W-1:0]        default_value;
	logic                    command;
	logic signed [KEY_W-1:0] range_begin;
	logic signed [KEY_W-1:0] range_end;
	logic [VAL_W-1:0]        new_value;
	logic signed [KEY_W-1:0] lookup_key;
	logic [VAL_W-1:0]        read_value;
	logic [1:0]              status;
	int                      mismatches, pending, n_lookups, n_empty, n_full;
	int                      cycles;
	int                      sent;

	interval_value_table i_dut (
		.clk, .arst_n, .start, .busy, .done, .default_value_we, .default_value,
		.command, .range_begin, .range_end, .new_value, .lookup_key,
		.read_value, .status
	);

	interval_value_table_check i_check (
		.clk, .arst_n, .start, .busy, .done, .default_value_we, .default_value,
		.command, .range_begin, .range_end, .new_value, .lookup_key,
		.read_value, .status, .mismatches, .pending, .n_lookups, .n_empty, .n_full
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("interval_value_table test failed");
				$finish;
			end
		end
	end

	// short gaps mostly, now and then a long one, often none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// keys cluster in a small window so ranges overlap; extremes now and then
	function automatic logic signed [KEY_W-1:0] pick_key(int span);
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) return {1'b1, {(KEY_W-1){1'b0}}};
		if (r == 1) return {1'b0, {(KEY_W-1){1'b1}}};
		if (r == 2) return $urandom;
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 2) == 0) return VAL_W'($urandom);
		return VAL_W'($urandom_range(0, 3));
	endfunction

	// hold one command until its transfer; busy only moves at a rising edge
	task automatic send(logic cmd, logic signed [KEY_W-1:0] b, logic signed [KEY_W-1:0] e,
			logic [VAL_W-1:0] v, logic signed [KEY_W-1:0] k, bit gaps);
		int g;
		start       <= 1'b1;
		command     <= cmd;
		range_begin <= b;
		range_end   <= e;
		new_value   <= v;
		lookup_key  <= k;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sent++;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_default(logic [VAL_W-1:0] v);
		drain();
		default_value_we <= 1'b1;
		default_value    <= v;
		@(posedge clk);
		default_value_we <= 1'b0;
	endtask

	// random phase: assigns and lookups, in one of two key layouts
	task automatic run_phase(int items, int span, bit spaced, bit gaps);
		logic signed [KEY_W-1:0] b, e;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				send(CMD_LOOKUP, $urandom, $urandom, VAL_W'($urandom),
					pick_key(span + 4), gaps);
			end else begin
				if (spaced) begin
					b = 4 * $signed($urandom_range(0, 2 * span)) - 4 * span;
					e = b + $urandom_range(1, 2);
				end else begin
					b = pick_key(span);
					e = ($urandom_range(0, 3) == 0) ? pick_key(span) : b + $urandom_range(0, 12);
				end
				send(CMD_ASSIGN, b, e, pick_value(), $urandom, gaps);
			end
		end
	endtask

	localparam logic signed [KEY_W-1:0] KMIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KMAX = {1'b0, {(KEY_W-1){1'b1}}};

	initial begin
		sent             = 0;
		arst_n           = 1'b0;
		start            = 1'b0;
		default_value_we = 1'b0;
		default_value    = '0;
		command          = CMD_ASSIGN;
		range_begin      = '0;
		range_end        = '0;
		new_value        = '0;
		lookup_key       = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, full key range, empty ranges, merges
		send(CMD_LOOKUP, 0, 0, 0, KMIN, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, KMAX, 1'b0);
		send(CMD_ASSIGN, KMIN, KMAX, '1, 0, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, KMIN, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, KMAX, 1'b0);
		send(CMD_ASSIGN, 5, 5, 9, 0, 1'b0);
		send(CMD_ASSIGN, KMAX, KMIN, 9, 0, 1'b0);
		send(CMD_ASSIGN, -5, 5, 7, 0, 1'b0);
		send(CMD_ASSIGN, 0, 3, 7, 0, 1'b0);
		send(CMD_ASSIGN, 5, 9, 7, 0, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, 4, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, 9, 1'b0);
		send(CMD_ASSIGN, KMIN, KMAX, 0, 0, 1'b0);
		send(CMD_ASSIGN, -1, 0, 8'h55, 0, 1'b0);
		send(CMD_ASSIGN, 0, 1, 8'haa, 0, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, -1, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, 0, 1'b0);
		send(CMD_ASSIGN, KMAX - 1, KMAX, 3, 0, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, KMAX - 1, 1'b0);

		// default changes leave the table as it is
		write_default(8'haa);
		send(CMD_LOOKUP, 0, 0, 0, KMIN, 1'b0);
		send(CMD_LOOKUP, 0, 0, 0, 0, 1'b0);
		send(CMD_ASSIGN, -3, 2, 8'haa, 0, 1'b0);

		write_default('1);
		run_phase(250, 40, 1'b0, 1'b1);
		write_default('0);
		run_phase(300, 60, 1'b1, 1'b1);
		write_default(VAL_W'($urandom));
		run_phase(300, 30, 1'b0, 1'b0);
		write_default(2);
		run_phase(350, 50, 1'b1, 1'b1);
		write_default(0);
		run_phase(330, 20, 1'b0, 1'b1);

		drain();
		repeat (200) @(posedge clk);
		$display("%0d commands sent: %0d lookups, %0d empty ranges, %0d refused as full",
			sent, n_lookups, n_empty, n_full);
		if (mismatches == 0 && pending == 0)
			$display("interval_value_table test passed");
		else
			$display("interval_value_table test failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/ivt_pkg.sv
sv/ivt_ctrl.sv
sv/ivt_dp.sv
sv/interval_value_table.sv
bench/interval_value_table_check.sv
bench/interval_value_table_test.sv
